[src/srpg_pkg.sv]
// Shared types, constants and a helper function of the stepper ramp pulse generator.
package srpg_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int PERIOD_BITS = 16;
   localparam int RAMP_BITS   = 16;
   localparam int DIV_BITS    = (PERIOD_BITS > RAMP_BITS) ? PERIOD_BITS : RAMP_BITS;
   localparam int CMP_BITS    = (COUNT_BITS > RAMP_BITS + 1) ? COUNT_BITS : RAMP_BITS + 1;
   localparam int IDX_BITS    = 2;

   localparam int REQ_BITS = ((COUNT_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_RAW  = 3 + PERIOD_BITS;
   localparam int RSP_BITS = ((RSP_RAW + 7) / 8) * 8;

   localparam logic [PERIOD_BITS-1:0] DIR_SETUP_TICKS = PERIOD_BITS'(10);
   localparam logic [PERIOD_BITS-1:0] MIN_HALF_TICKS  = PERIOD_BITS'(5);

   localparam logic [PERIOD_BITS-1:0] START_PERIOD_RESET  = PERIOD_BITS'(2000);
   localparam logic [PERIOD_BITS-1:0] TARGET_PERIOD_RESET = PERIOD_BITS'(500);
   localparam logic [RAMP_BITS-1:0]   RAMP_LENGTH_RESET   = RAMP_BITS'(200);

   localparam logic [IDX_BITS-1:0] REG_START_PERIOD  = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] REG_TARGET_PERIOD = IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] REG_RAMP_LENGTH   = IDX_BITS'(2);

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SETUP,
      PH_HIGH,
      PH_LOW
   } srpg_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FIN_ACC,
      ST_FIN_DEC,
      ST_RESP
   } srpg_state_type;

   typedef struct packed {
      logic latch_in;
      logic exec;
      logic div_start;
      logic div_store;
      logic fin_acc;
      logic fin_dec;
      logic load_rsp;
   } srpg_cmd_type;

   typedef struct packed {
      logic is_start;
      logic start_ok;
      logic need_finish;
      logic div_done;
   } srpg_sts_type;

   // Half of a period, never shorter than the minimum pulse width.
   function automatic logic [PERIOD_BITS-1:0] half_of(input logic [PERIOD_BITS-1:0] p);
      logic [PERIOD_BITS-1:0] h;
      h = p >> 1;
      return (h < MIN_HALF_TICKS) ? MIN_HALF_TICKS : h;
   endfunction

endpackage

[src/srpg_div.sv]
// Restoring divider, one quotient bit per cycle, used for the ramp period step.
module srpg_div
   import srpg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] quotient
);

   localparam int CNT_BITS = (DIV_BITS > 1) ? $clog2(DIV_BITS) : 1;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0] dsr_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [DIV_BITS:0]   shifted;
   logic [DIV_BITS:0]   diff;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_BITS-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});
      rem_in  = fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
      quo_in  = {quo_ff[DIV_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/srpg_dp.sv]
// Datapath: configuration registers, move state, period ramp arithmetic and result register.
module srpg_dp
   import srpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  srpg_cmd_type           cmd,
   output srpg_sts_type           sts,
   input  logic                   csr_we,
   input  logic [IDX_BITS-1:0]    csr_index,
   input  logic [PERIOD_BITS-1:0] csr_data,
   input  logic                   in_op,
   input  logic [COUNT_BITS-1:0]  in_steps,
   input  logic                   in_dir,
   output logic                   out_pulse,
   output logic                   out_dir,
   output logic                   out_busy,
   output logic [PERIOD_BITS-1:0] out_period
);

   // Configuration registers.
   logic [PERIOD_BITS-1:0] start_cfg_ff, target_cfg_ff;
   logic [RAMP_BITS-1:0]   ramp_cfg_ff;

   // Held request.
   logic                  op_ff;
   logic [COUNT_BITS-1:0] steps_ff;
   logic                  dir_in_ff;

   // Move state.
   srpg_phase_type         phase_ff, phase_in;
   logic [PERIOD_BITS-1:0] tick_ff, tick_in;
   logic [PERIOD_BITS-1:0] cur_ff, cur_in;
   logic [PERIOD_BITS-1:0] delta_ff, delta_in;
   logic [RAMP_BITS-1:0]   ramp_ff, ramp_in;
   logic [COUNT_BITS-1:0]  total_ff, total_in;
   logic [COUNT_BITS-1:0]  index_ff, index_in;
   logic [COUNT_BITS-1:0]  decel_ff, decel_in;
   logic                   ramp_le_ff, ramp_le_in;
   logic                   dir_ff, dir_in;
   logic [PERIOD_BITS-1:0] mv_start_ff, mv_start_in;
   logic [PERIOD_BITS-1:0] mv_target_ff, mv_target_in;
   logic                   mv_gt_ff, mv_gt_in;

   // Result register.
   logic                   rsp_pulse_ff, rsp_dir_ff, rsp_busy_ff;
   logic [PERIOD_BITS-1:0] rsp_period_ff;

   // Scratch values.
   logic [CMP_BITS-1:0]    steps_x, ramp_x2;
   logic [RAMP_BITS-1:0]   ramp_pick;
   logic [CMP_BITS-1:0]    decel_x;
   logic [PERIOD_BITS-1:0] cnt_dec;
   logic                   cnt_zero;
   logic [PERIOD_BITS-1:0] acc_p;
   logic [PERIOD_BITS:0]   dec_sum;
   logic [PERIOD_BITS-1:0] dec_p;
   logic [COUNT_BITS-1:0]  next_index;
   logic [DIV_BITS-1:0]    div_num, div_den, div_quo;
   logic [PERIOD_BITS-1:0] quo_p;
   logic                   div_done;

   srpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Effective ramp: requested length, cut to half the steps, at least one.
   always_comb begin
      steps_x = CMP_BITS'(steps_ff);
      ramp_x2 = CMP_BITS'({ramp_cfg_ff, 1'b0});
      if (ramp_x2 > steps_x) begin
         ramp_pick = RAMP_BITS'(steps_x >> 1);
      end else begin
         ramp_pick = ramp_cfg_ff;
      end
      if (ramp_pick == '0) begin
         ramp_pick = RAMP_BITS'(1);
      end
      decel_x = steps_x - CMP_BITS'(ramp_pick);
      div_den = DIV_BITS'(ramp_pick);
      if (start_cfg_ff > target_cfg_ff) begin
         div_num = DIV_BITS'(start_cfg_ff - target_cfg_ff);
      end else begin
         div_num = '0;
      end
   end

   assign cnt_dec  = (tick_ff != '0) ? tick_ff - PERIOD_BITS'(1) : '0;
   assign cnt_zero = (cnt_dec == '0);
   assign quo_p    = PERIOD_BITS'(div_quo);

   assign sts.is_start    = (op_ff == OP_START);
   assign sts.start_ok    = (op_ff == OP_START) && (phase_ff == PH_IDLE);
   assign sts.need_finish = (op_ff == OP_TICK) && (phase_ff == PH_LOW) && cnt_zero;
   assign sts.div_done    = div_done;

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      cur_in       = cur_ff;
      delta_in     = delta_ff;
      ramp_in      = ramp_ff;
      total_in     = total_ff;
      index_in     = index_ff;
      decel_in     = decel_ff;
      ramp_le_in   = ramp_le_ff;
      dir_in       = dir_ff;
      mv_start_in  = mv_start_ff;
      mv_target_in = mv_target_ff;
      mv_gt_in     = mv_gt_ff;
      acc_p        = cur_ff;
      dec_sum      = {1'b0, cur_ff} + {1'b0, delta_ff};
      dec_p        = cur_ff;
      next_index   = index_ff + COUNT_BITS'(1);

      if (cmd.exec) begin
         if (op_ff == OP_START) begin
            if (phase_ff == PH_IDLE) begin
               dir_in       = dir_in_ff;
               total_in     = steps_ff;
               index_in     = '0;
               mv_start_in  = start_cfg_ff;
               mv_target_in = target_cfg_ff;
               mv_gt_in     = (start_cfg_ff > target_cfg_ff);
               ramp_in      = ramp_pick;
               decel_in     = COUNT_BITS'(decel_x);
               ramp_le_in   = (CMP_BITS'(ramp_pick) <= steps_x);
               delta_in     = '0;
               cur_in       = start_cfg_ff;
               tick_in      = DIR_SETUP_TICKS;
               phase_in     = PH_SETUP;
            end
         end else begin
            case (phase_ff)
               PH_SETUP: begin
                  tick_in = cnt_dec;
                  if (cnt_zero) begin
                     if (total_ff == '0) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_HIGH;
                        tick_in  = half_of(cur_ff);
                     end
                  end
               end
               PH_HIGH: begin
                  tick_in = cnt_dec;
                  if (cnt_zero) begin
                     phase_in = PH_LOW;
                     tick_in  = half_of(cur_ff);
                  end
               end
               PH_LOW: begin
                  tick_in = cnt_dec;
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.div_store) begin
         if (mv_gt_ff) begin
            delta_in = (quo_p == '0) ? PERIOD_BITS'(1) : quo_p;
         end else begin
            delta_in = '0;
         end
      end

      // Acceleration half of the step update.
      if (cmd.fin_acc) begin
         if ((CMP_BITS'(index_ff) < CMP_BITS'(ramp_ff)) && (cur_ff > mv_target_ff)) begin
            acc_p = (cur_ff > delta_ff) ? cur_ff - delta_ff : mv_target_ff;
            if (acc_p < mv_target_ff) begin
               acc_p = mv_target_ff;
            end
         end
         cur_in = acc_p;
      end

      // Deceleration half, then advance to the next step or finish the move.
      if (cmd.fin_dec) begin
         if (ramp_le_ff && (index_ff >= decel_ff) && (cur_ff < mv_start_ff)) begin
            dec_p = (dec_sum > {1'b0, mv_start_ff}) ? mv_start_ff : dec_sum[PERIOD_BITS-1:0];
         end
         cur_in   = dec_p;
         index_in = next_index;
         if (next_index >= total_ff) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_HIGH;
            tick_in  = half_of(dec_p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_cfg_ff  <= START_PERIOD_RESET;
         target_cfg_ff <= TARGET_PERIOD_RESET;
         ramp_cfg_ff   <= RAMP_LENGTH_RESET;
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         cur_ff        <= '0;
         delta_ff      <= '0;
         ramp_ff       <= '0;
         total_ff      <= '0;
         index_ff      <= '0;
         decel_ff      <= '0;
         ramp_le_ff    <= 1'b0;
         dir_ff        <= 1'b0;
         mv_start_ff   <= '0;
         mv_target_ff  <= '0;
         mv_gt_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_START_PERIOD:  start_cfg_ff  <= csr_data;
               REG_TARGET_PERIOD: target_cfg_ff <= csr_data;
               REG_RAMP_LENGTH:   ramp_cfg_ff   <= RAMP_BITS'(csr_data);
               default: begin
               end
            endcase
         end
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         cur_ff       <= cur_in;
         delta_ff     <= delta_in;
         ramp_ff      <= ramp_in;
         total_ff     <= total_in;
         index_ff     <= index_in;
         decel_ff     <= decel_in;
         ramp_le_ff   <= ramp_le_in;
         dir_ff       <= dir_in;
         mv_start_ff  <= mv_start_in;
         mv_target_ff <= mv_target_in;
         mv_gt_ff     <= mv_gt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         op_ff     <= in_op;
         steps_ff  <= in_steps;
         dir_in_ff <= in_dir;
      end
      if (cmd.load_rsp) begin
         rsp_pulse_ff  <= (phase_ff == PH_HIGH);
         rsp_dir_ff    <= dir_ff;
         rsp_busy_ff   <= (phase_ff != PH_IDLE);
         rsp_period_ff <= cur_ff;
      end
   end

   assign out_pulse  = rsp_pulse_ff;
   assign out_dir    = rsp_dir_ff;
   assign out_busy   = rsp_busy_ff;
   assign out_period = rsp_period_ff;

endmodule

[src/srpg_ctl.sv]
// Controller: sequences each transaction through the datapath and owns the handshakes.
module srpg_ctl
   import srpg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  srpg_sts_type sts,
   output srpg_cmd_type cmd
);

   srpg_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   // The result register is free, or is being emptied in this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = rsp_free;
            if (req_tvalid && rsp_free) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.is_start) begin
               if (sts.start_ok) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (sts.need_finish) begin
               state_in = ST_FIN_ACC;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_FIN_ACC: begin
            cmd.fin_acc = 1'b1;
            state_in    = ST_FIN_DEC;
         end
         ST_FIN_DEC: begin
            cmd.fin_dec = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            cmd.load_rsp = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[src/stepper_ramp_pulse_generator.sv]
// Top level of the stepper ramp pulse generator: controller, datapath and port packing.
//
// Each request transaction is either a one-microsecond tick (req_tuser low) or a start
// command (req_tuser high) that carries a step count and a direction in req_tdata.
// Every request produces exactly one response transaction carrying the step pin level,
// the direction pin level, a busy flag and the step period in use after that request.
// A start while a move is running is ignored and still answered.
// The three configuration registers are written through the csr_ channel, which is
// always ready; a new value is used from the next start command on.
// One request is in work at a time. A tick goes from acceptance through the execute and
// response states; a tick that ends a step also passes the acceleration and deceleration
// states, which run the period update of the finished step. A start command waits for
// the bit-serial divider that computes the per-step period change.
// The response sits in an output register; the next request is accepted as soon as
// that register is empty or is being read in the same cycle, so a stalled receiver
// holds back the request side once its single response slot is full.
// Synchronous reset returns the move to idle, direction and period at zero, configuration
// registers at defaults, no response pending; the response register itself is not reset.
module stepper_ramp_pulse_generator
   import srpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_BITS-1:0]    req_tdata,  // step_count, direction, zero fill
   input  logic                   req_tuser,  // op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_BITS-1:0]    rsp_tdata,  // pulse_level, dir_level, busy_res,
                                              // active_period, zero fill
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [IDX_BITS-1:0]    csr_index,
   input  logic [PERIOD_BITS-1:0] csr_data
);

   srpg_cmd_type           cmd;
   srpg_sts_type           sts;
   logic                   out_pulse;
   logic                   out_dir;
   logic                   out_busy;
   logic [PERIOD_BITS-1:0] out_period;

   // Configuration writes never stall.
   assign csr_ready = 1'b1;

   srpg_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   srpg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .in_op      (req_tuser),
      .in_steps   (req_tdata[COUNT_BITS-1:0]),
      .in_dir     (req_tdata[COUNT_BITS]),
      .out_pulse  (out_pulse),
      .out_dir    (out_dir),
      .out_busy   (out_busy),
      .out_period (out_period)
   );

   // The upper bits of req_tdata are zero fill and are not used.
   assign rsp_tdata = {{(RSP_BITS - RSP_RAW){1'b0}}, out_period, out_busy, out_dir, out_pulse};

`ifndef SYNTHESIS
   // Only one transaction is in work, so the request side closes right after an acceptance.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another transaction is in work");

   // A request is never accepted while an unread response would be overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("request accepted with a stalled response pending");

   // The step pin is only high while a move is running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[2]))
      else $error("step pulse reported while idle");
`endif

endmodule
